### hw/rtl/cgrg_pkg.sv
// ============================================================================
// cgrg_pkg
// Shared constants, control types and the seed conditioning function of the
// combined R250/R521 GFSR generator.
// ============================================================================
`default_nettype none

package cgrg_pkg;

    localparam int SHORT_DEPTH = 250;
    localparam int LONG_DEPTH  = 521;
    localparam int SHORT_LAG   = 103;
    localparam int LONG_LAG    = 168;
    localparam int TOTAL_WORDS = SHORT_DEPTH + LONG_DEPTH;
    localparam int COND_COUNT  = 31;
    localparam int SHORT_STEP  = 7;
    localparam int LONG_STEP   = 13;

    localparam int WORD_W = 31;
    localparam int SP_W   = $clog2(SHORT_DEPTH);
    localparam int LP_W   = $clog2(LONG_DEPTH);
    localparam int POS_W  = $clog2(TOTAL_WORDS + 1);
    localparam int COND_W = $clog2(COND_COUNT);

    localparam logic [WORD_W-1:0] WORD_MASK = 31'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] TOP_BIT   = 31'h4000_0000;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_GEN  = 1'b1;

    typedef struct packed {
        logic              shift;     // move every cell one place toward the head
        logic              feedback;  // tail takes head ^ lag tap (else head)
        logic              wr;
        logic [SP_W-1:0]   idx;
        logic [WORD_W-1:0] data;
    } t_short_ctl;

    typedef struct packed {
        logic              shift;
        logic              feedback;
        logic              wr;
        logic [LP_W-1:0]   idx;
        logic [WORD_W-1:0] data;
    } t_long_ctl;

    typedef struct packed {
        logic              busy;      // rotating both rows back to pointer zero
        logic [SP_W-1:0]   sp;
        logic [LP_W-1:0]   lp;
        logic [POS_W-1:0]  lpos;
    } t_ctrl_stat;

    // Words on the diagonal 3 + step*i get their top bits cleared and bit 30-i set.
    function automatic logic [WORD_W-1:0] condition_word(
        input logic [WORD_W-1:0] word,
        input logic [POS_W-1:0]  pos,
        input int                step
    );
        logic              hit;
        logic [COND_W-1:0] sel;
        logic [WORD_W-1:0] res;
        hit = 1'b0;
        sel = '0;
        for (int i = 0; i < COND_COUNT; i++) begin
            if (pos == POS_W'(3 + step * i)) begin
                hit = 1'b1;
                sel = COND_W'(i);
            end
        end
        res = hit ? ((word & (WORD_MASK >> sel)) | (TOP_BIT >> sel)) : word;
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/cgrg_if.sv
// ============================================================================
// cgrg_if
// Valid/ready stream interfaces for the generator's item and result channels.
// ============================================================================
`default_nettype none

interface cgrg_in_if import cgrg_pkg::*; ;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [WORD_W-1:0] seed_word;
    logic              load_first;

    modport source (output valid, kind, seed_word, load_first, input ready);
    modport sink   (input valid, kind, seed_word, load_first, output ready);
endinterface

interface cgrg_out_if import cgrg_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_value;

    modport source (output valid, random_value, input ready);
    modport sink   (input valid, random_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/cgrg_cell.sv
// ============================================================================
// cgrg_cell
// One 31-bit word of a store row: takes the word fed to it on a shift (its
// neighbor's, or the feedback word at the tail), or a seed word when addressed by a load.
// ============================================================================
`default_nettype none

module cgrg_cell import cgrg_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_shift,
    input  wire logic [WORD_W-1:0] i_shift_data,
    input  wire logic              i_wr,
    input  wire logic [WORD_W-1:0] i_wr_data,
    output logic      [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0] r_word;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_word <= i_wr_data;
        end else if (i_shift) begin
            r_word <= i_shift_data;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

### hw/rtl/cgrg_ctrl.sv
// ============================================================================
// cgrg_ctrl
// Pointer, load position and restart control. Each row holds its store
// rotated by its pointer, so cell k is entry (k + pointer) mod depth. A load
// restart turns the rows until both pointers are back at zero.
// ============================================================================
`default_nettype none

module cgrg_ctrl import cgrg_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic              i_kind,
    input  wire logic [WORD_W-1:0] i_seed_word,
    input  wire logic              i_load_first,
    output t_short_ctl             o_short_ctl,
    output t_long_ctl              o_long_ctl,
    output t_ctrl_stat             o_stat
);

    logic [SP_W-1:0]  r_sp, n_sp, sp_inc;
    logic [LP_W-1:0]  r_lp, n_lp, lp_inc;
    logic [POS_W-1:0] r_lpos, n_lpos;
    logic             r_realign, n_realign;

    logic             is_load, is_gen, in_range, in_short;
    logic             rot_s, rot_l;
    logic [POS_W-1:0] pos, long_pos;
    logic [SP_W-1:0]  short_pos, short_idx;
    logic [LP_W-1:0]  long_q, long_idx;

    always_comb begin
        is_load   = i_fire && (i_kind == KIND_LOAD);
        is_gen    = i_fire && (i_kind == KIND_GEN);
        pos       = i_load_first ? '0 : r_lpos;
        in_range  = pos < POS_W'(TOTAL_WORDS);
        in_short  = pos < POS_W'(SHORT_DEPTH);
        long_pos  = pos - POS_W'(SHORT_DEPTH);
        short_pos = pos[SP_W-1:0];
        long_q    = long_pos[LP_W-1:0];

        // physical cell = (entry - pointer) mod depth
        short_idx = (short_pos >= r_sp) ? (short_pos - r_sp)
                                        : (short_pos + SP_W'(SHORT_DEPTH) - r_sp);
        long_idx  = (long_q >= r_lp) ? (long_q - r_lp)
                                     : (long_q + LP_W'(LONG_DEPTH) - r_lp);

        sp_inc = (r_sp == SP_W'(SHORT_DEPTH - 1)) ? '0 : r_sp + 1'b1;
        lp_inc = (r_lp == LP_W'(LONG_DEPTH - 1)) ? '0 : r_lp + 1'b1;

        rot_s = r_realign && (r_sp != '0);
        rot_l = r_realign && (r_lp != '0);

        n_sp = (is_gen || rot_s) ? sp_inc : r_sp;
        n_lp = (is_gen || rot_l) ? lp_inc : r_lp;

        if (r_realign) begin
            n_realign = (n_sp != '0) || (n_lp != '0);
        end else begin
            n_realign = is_load && i_load_first && ((r_sp != '0) || (r_lp != '0));
        end

        n_lpos = r_lpos;
        if (is_load && in_range) begin
            n_lpos = pos + 1'b1;
        end

        o_short_ctl.shift    = is_gen || rot_s;
        o_short_ctl.feedback = is_gen;
        o_short_ctl.wr       = is_load && in_range && in_short;
        o_short_ctl.idx      = short_idx;
        o_short_ctl.data     = condition_word(i_seed_word, pos, SHORT_STEP);

        o_long_ctl.shift     = is_gen || rot_l;
        o_long_ctl.feedback  = is_gen;
        o_long_ctl.wr        = is_load && in_range && !in_short;
        o_long_ctl.idx       = long_idx;
        o_long_ctl.data      = condition_word(i_seed_word, long_pos, LONG_STEP);

        o_stat.busy = r_realign;
        o_stat.sp   = r_sp;
        o_stat.lp   = r_lp;
        o_stat.lpos = r_lpos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_lp      <= '0;
            r_lpos    <= '0;
            r_realign <= 1'b0;
        end else begin
            r_sp      <= n_sp;
            r_lp      <= n_lp;
            r_lpos    <= n_lpos;
            r_realign <= n_realign;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/combined_gfsr_random_generator.sv
// ============================================================================
// combined_gfsr_random_generator
// Combined R250/R521 lagged-XOR generator built from two rows of word cells.
// ============================================================================
// Usage:
//   i_in carries items: kind 0 loads seed_word into the next store position
//   (load_first restarts at position zero), kind 1 generates one value.
//   The 771 seed words go in order, short store first, then the long one.
//   o_out carries one random_value per generate; loads give no result.
// Throughput: one item per cycle. Each row shifts one cell per generate, the
//   head and lag taps feed the tail, so no item waits on the one before it.
// Results: a generate's result is registered in the output or skid register.
// Restart: a load with load_first after generating turns both rows back to
//   pointer zero, one cell per cycle; i_in.ready stays low meanwhile.
// Stall: an output register plus one skid register; items keep being taken
//   until both hold a result, then ready drops until o_out drains.
// Reset: pointers and load position go to zero, no results pending; store
//   words are undefined until loaded.
// ============================================================================
`default_nettype none

module combined_gfsr_random_generator import cgrg_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cgrg_in_if.sink     i_in,
    cgrg_out_if.source  o_out
);

    t_short_ctl short_ctl;
    t_long_ctl  long_ctl;
    t_ctrl_stat stat;

    logic              in_fire, gen_fire, out_fire;
    logic [WORD_W-1:0] s_word [SHORT_DEPTH];
    logic [WORD_W-1:0] l_word [LONG_DEPTH];
    logic [WORD_W-1:0] s_new, l_new, s_tail, l_tail, result;

    logic              r_out_valid, r_skid_valid;
    logic [WORD_W-1:0] r_out_data, r_skid_data;

    assign i_in.ready = !stat.busy && !r_skid_valid;
    assign in_fire    = i_in.valid && i_in.ready;
    assign gen_fire   = in_fire && (i_in.kind == KIND_GEN);
    assign out_fire   = r_out_valid && o_out.ready;

    cgrg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_kind       (i_in.kind),
        .i_seed_word  (i_in.seed_word),
        .i_load_first (i_in.load_first),
        .o_short_ctl  (short_ctl),
        .o_long_ctl   (long_ctl),
        .o_stat       (stat)
    );

    assign s_new  = s_word[0] ^ s_word[SHORT_LAG];
    assign l_new  = l_word[0] ^ l_word[LONG_LAG];
    assign s_tail = short_ctl.feedback ? s_new : s_word[0];
    assign l_tail = long_ctl.feedback ? l_new : l_word[0];
    assign result = s_new ^ l_new;

    for (genvar k = 0; k < SHORT_DEPTH; k++) begin : g_short
        logic [WORD_W-1:0] nxt;
        if (k == SHORT_DEPTH - 1) begin : g_tail
            assign nxt = s_tail;
        end else begin : g_mid
            assign nxt = s_word[k + 1];
        end
        cgrg_cell u_cell (
            .i_clk        (i_clk),
            .i_shift      (short_ctl.shift),
            .i_shift_data (nxt),
            .i_wr         (short_ctl.wr && (short_ctl.idx == SP_W'(k))),
            .i_wr_data    (short_ctl.data),
            .o_word       (s_word[k])
        );
    end

    for (genvar k = 0; k < LONG_DEPTH; k++) begin : g_long
        logic [WORD_W-1:0] nxt;
        if (k == LONG_DEPTH - 1) begin : g_tail
            assign nxt = l_tail;
        end else begin : g_mid
            assign nxt = l_word[k + 1];
        end
        cgrg_cell u_cell (
            .i_clk        (i_clk),
            .i_shift      (long_ctl.shift),
            .i_shift_data (nxt),
            .i_wr         (long_ctl.wr && (long_ctl.idx == LP_W'(k))),
            .i_wr_data    (long_ctl.data),
            .o_word       (l_word[k])
        );
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire) begin
            if (r_skid_valid) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= gen_fire;
                if (gen_fire) begin
                    r_out_data <= result;
                end
            end
        end else if (gen_fire) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
                r_out_data  <= result;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_data  <= result;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.random_value = r_out_data;

    a_realign_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(stat.busy) |-> (stat.sp == '0) && (stat.lp == '0))
        else $error("restart rotation ended with a pointer off zero");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_gen_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gen_fire |=> r_out_valid)
        else $error("generate transfer left no result pending");

    a_lpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.lpos <= POS_W'(TOTAL_WORDS))
        else $error("load position past the end of the stores");

endmodule

`default_nettype wire
